// ===== rtl/stopwatch_with_long_press_off_top_assert.svh =====
// Assertion macros for the stopwatch checker.
// Plain text macros; no dependencies.
`ifndef STOPWATCH_WITH_LONG_PRESS_OFF_TOP_ASSERT_SVH
`define STOPWATCH_WITH_LONG_PRESS_OFF_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWLP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWLP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swlp_pkg.sv =====
// Shared types and constants of the stopwatch block.
// No dependencies.
package swlp_pkg;

  localparam int STAMP_W  = 16;
  localparam int PERIOD_W = 17;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_EDGE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_COUNTING = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_OFF      = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;

  localparam logic [9:0] MILLI_MAX  = 10'd999;
  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [6:0] MINUTE_MAX = 7'd99;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd300;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd20001;

  // One remainder lane: partial remainder and the dividend bits not yet consumed.
  typedef struct packed {
    logic [STAMP_W-1:0] rem;
    logic [STAMP_W-1:0] bits;
  } lane_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  edge_second;
    lane_t la;
    lane_t lb;
  } stage_t;

endpackage

// ===== rtl/swlp_in_if.sv =====
// Input event channel: valid/ready handshake with cmd and edge_time.
// Depends on nothing.
interface swlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] edge_time;

  modport source (output valid, output cmd, output edge_time, input ready);
  modport sink (input valid, input cmd, input edge_time, output ready);
endinterface

// ===== rtl/swlp_out_if.sv =====
// Result channel: valid/ready handshake with the displayed count and run state.
// Depends on nothing.
interface swlp_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] minutes;
  logic [5:0] seconds;
  logic [9:0] millis;
  logic [1:0] run_state;

  modport source (output valid, output minutes, output seconds, output millis,
                  output run_state, input ready);
  modport sink (input valid, input minutes, input seconds, input millis,
                input run_state, output ready);
endinterface

// ===== rtl/swlp_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on nothing.
interface swlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/swlp_cfg_regs.sv =====
// Configuration registers: long-press limit and timestamp counter period.
// Depends on swlp_pkg and swlp_cfg_if.
module swlp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  swlp_cfg_if.sink                    cfg,
  output logic [swlp_pkg::LIMIT_W-1:0]  limit,
  output logic [swlp_pkg::PERIOD_W-1:0] period
);
  import swlp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= LIMIT_RESET;
      period <= PERIOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LIMIT:  limit  <= cfg.data[LIMIT_W-1:0];
        REG_PERIOD: period <= cfg.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/swlp_rem_pipe.sv =====
// Pipelined restoring remainder: reduces both edge stamps modulo the period,
// one dividend bit per stage. Depends on swlp_pkg.
module swlp_rem_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          head_valid,
  input  swlp_pkg::stage_t              head,
  input  logic [swlp_pkg::PERIOD_W-1:0] period,
  output logic                          tail_valid,
  output swlp_pkg::stage_t              tail
);
  import swlp_pkg::*;

  localparam int STEPS = STAMP_W;

  stage_t            pipe_q [STEPS];
  logic [STEPS-1:0]  valid_q;

  // A zero period means 2^17, larger than any stamp: never subtract.
  function automatic lane_t rem_step(lane_t l, logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] r2;
    lane_t               res;
    r2 = {l.rem, l.bits[STAMP_W-1]};
    if (p != '0 && r2 >= p) begin
      r2 = r2 - p;
    end
    res.rem  = r2[STAMP_W-1:0];
    res.bits = {l.bits[STAMP_W-2:0], 1'b0};
    return res;
  endfunction

  function automatic stage_t stage_step(stage_t s, logic [PERIOD_W-1:0] p);
    stage_t res;
    res    = s;
    res.la = rem_step(s.la, p);
    res.lb = rem_step(s.lb, p);
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[STEPS-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe_q[0] <= stage_step(head, period);
      for (int k = 1; k < STEPS; k++) begin
        pipe_q[k] <= stage_step(pipe_q[k-1], period);
      end
    end
  end

  assign tail_valid = valid_q[STEPS-1];
  assign tail       = pipe_q[STEPS-1];

endmodule

// ===== rtl/swlp_core.sv =====
// Stopwatch state and result register: run mode, time count, long-press check.
// Depends on swlp_pkg and swlp_out_if.
module swlp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          stg_valid,
  input  swlp_pkg::stage_t              stg,
  input  logic [swlp_pkg::PERIOD_W-1:0] period,
  input  logic [swlp_pkg::LIMIT_W-1:0]  limit,
  output logic                          advance,
  swlp_out_if.source                    resp
);
  import swlp_pkg::*;

  localparam int GAP_W = PERIOD_W + 1;
  localparam logic [GAP_W-1:0] PERIOD_ZERO_EFF = 18'h20000;

  mode_t      mode, mode_next;
  logic [6:0] minute_count, minute_next;
  logic [5:0] second_count, second_next;
  logic [9:0] milli_count, milli_next;
  logic       out_valid;

  logic [10:0]      milli_tmp;
  logic [6:0]       second_tmp;
  logic [7:0]       minute_tmp;
  logic [GAP_W-1:0] p_eff, gap;
  logic             long_press;

  assign advance = !out_valid || resp.ready;

  // Edge gap modulo the period, in 0 .. period-1.
  always_comb begin
    p_eff = (period == '0) ? PERIOD_ZERO_EFF : {1'b0, period};
    if (stg.la.rem >= stg.lb.rem) begin
      gap = {2'b00, stg.la.rem} - {2'b00, stg.lb.rem};
    end else begin
      gap = {2'b00, stg.la.rem} + p_eff - {2'b00, stg.lb.rem};
    end
    long_press = gap > {2'b00, limit};
  end

  // One tick with carries; out-of-range digits wrap to zero.
  always_comb begin
    milli_tmp  = {1'b0, milli_count} + 11'd1;
    second_tmp = {1'b0, second_count};
    minute_tmp = {1'b0, minute_count};
    if (milli_tmp > {1'b0, MILLI_MAX}) begin
      milli_tmp  = '0;
      second_tmp = second_tmp + 7'd1;
    end
    if (second_tmp > {1'b0, SECOND_MAX}) begin
      second_tmp = '0;
      minute_tmp = minute_tmp + 8'd1;
    end
    if (minute_tmp > {1'b0, MINUTE_MAX}) begin
      minute_tmp = '0;
    end
  end

  always_comb begin
    mode_next   = mode;
    minute_next = minute_count;
    second_next = second_count;
    milli_next  = milli_count;
    if (mode != MODE_OFF) begin
      unique case (stg.cmd)
        CMD_TICK: begin
          if (mode == MODE_COUNTING) begin
            milli_next  = milli_tmp[9:0];
            second_next = second_tmp[5:0];
            minute_next = minute_tmp[6:0];
          end
        end
        CMD_START: mode_next = MODE_COUNTING;
        CMD_PAUSE: mode_next = MODE_PAUSED;
        CMD_EDGE: begin
          mode_next   = (stg.edge_second && long_press) ? MODE_OFF : MODE_STOPPED;
          minute_next = '0;
          second_next = '0;
          milli_next  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_STOPPED;
      minute_count <= '0;
      second_count <= '0;
      milli_count  <= '0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid;
      if (stg_valid) begin
        mode         <= mode_next;
        minute_count <= minute_next;
        second_count <= second_next;
        milli_count  <= milli_next;
      end
    end
  end

  // The state registers are the result register: they change only on a load.
  assign resp.valid     = out_valid;
  assign resp.minutes   = minute_count;
  assign resp.seconds   = second_count;
  assign resp.millis    = milli_count;
  assign resp.run_state = mode;

endmodule

// ===== rtl/stopwatch_with_long_press_off_top.sv =====
// Stopwatch with long-press power-off. One event is taken per clock cycle
// while no finished result is stalled on resp; its result (count and run
// state after the event) passes the 16-stage remainder pipeline that reduces
// reset-edge stamps modulo counter_period and is then registered in the core.
// The whole pipeline holds while a finished result waits on resp, so
// req.ready is low only then. Configuration writes are always ready and
// take effect at once; write them only while no event is in flight.
module stopwatch_with_long_press_off_top (
  input  logic       clk,
  input  logic       rst,
  swlp_in_if.sink    req,
  swlp_out_if.source resp,
  swlp_cfg_if.sink   cfg
);
  import swlp_pkg::*;

  logic [LIMIT_W-1:0]  limit;
  logic [PERIOD_W-1:0] period;
  logic                advance;
  logic                in_xfer;
  logic                entry_phase;
  logic [STAMP_W-1:0]  first_stamp;
  cmd_t                req_cmd;
  stage_t              head;
  stage_t              tail;
  logic                tail_valid;

  swlp_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limit  (limit),
    .period (period)
  );

  assign req.ready = advance;
  assign in_xfer   = req.valid && advance;
  assign req_cmd   = cmd_t'(req.cmd);

  // Track the edge phase at entry so the first stamp rides along with the
  // edge that closes the pair. Once the watch is off nothing downstream reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_phase <= 1'b0;
      first_stamp <= '0;
    end else if (in_xfer && req_cmd == CMD_EDGE) begin
      entry_phase <= ~entry_phase;
      if (!entry_phase) begin
        first_stamp <= req.edge_time;
      end
    end
  end

  always_comb begin
    head.cmd         = req_cmd;
    head.edge_second = entry_phase && (req_cmd == CMD_EDGE);
    head.la.rem      = '0;
    head.la.bits     = req.edge_time;
    head.lb.rem      = '0;
    head.lb.bits     = first_stamp;
  end

  swlp_rem_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .head_valid (in_xfer),
    .head       (head),
    .period     (period),
    .tail_valid (tail_valid),
    .tail       (tail)
  );

  swlp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .stg_valid (tail_valid),
    .stg       (tail),
    .period    (period),
    .limit     (limit),
    .advance   (advance),
    .resp      (resp)
  );

endmodule

// ===== rtl/swlp_checker.sv =====
// Port-level checker for the stopwatch top level, attached by bind.
// Depends on swlp_pkg and the assertion macro header.
`include "stopwatch_with_long_press_off_top_assert.svh"

module swlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       resp_valid,
  input logic       resp_ready,
  input logic [6:0] minutes,
  input logic [5:0] seconds,
  input logic [9:0] millis,
  input logic [1:0] run_state
);
  import swlp_pkg::*;

  logic seen_off;
  logic count_zero;

  assign count_zero = (minutes == '0) && (seconds == '0) && (millis == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_off <= 1'b0;
    end else if (resp_valid && resp_ready && run_state == MODE_OFF) begin
      seen_off <= 1'b1;
    end
  end

  `SWLP_ASSERT_IMP(a_count_range, clk, rst, resp_valid,
    millis <= MILLI_MAX && seconds <= SECOND_MAX && minutes <= MINUTE_MAX,
    "count digit out of range")

  `SWLP_ASSERT_IMP(a_idle_zero, clk, rst,
    resp_valid && (run_state == MODE_STOPPED || run_state == MODE_OFF), count_zero,
    "stopped or off with a nonzero count")

  `SWLP_ASSERT_IMP(a_off_sticky, clk, rst, resp_valid && seen_off,
    run_state == MODE_OFF, "watch left the off state")

  `SWLP_ASSERT_NXT(a_resp_hold, clk, rst, resp_valid && !resp_ready,
    resp_valid && $stable(minutes) && $stable(seconds) && $stable(millis)
      && $stable(run_state), "stalled result changed")

endmodule

bind stopwatch_with_long_press_off_top swlp_checker u_swlp_checker (
  .clk        (clk),
  .rst        (rst),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .minutes    (resp.minutes),
  .seconds    (resp.seconds),
  .millis     (resp.millis),
  .run_state  (resp.run_state)
);
